### rtl/core/bclp_pkg.sv
// ----------------------------------------------------------------------------
// bclp_pkg: shared types and constants of the bus command line parser
// Status codes, result item layout and the output queue geometry.
// ----------------------------------------------------------------------------
package bclp_pkg;

  localparam int MAX_WRITE_BYTES = 16;

  // write counter wide enough to reach MAX_WRITE_BYTES, never below the field width
  localparam int WCNT_W = ($clog2(MAX_WRITE_BYTES + 1) > 5) ?
                          $clog2(MAX_WRITE_BYTES + 1) : 5;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  typedef logic [3:0] status_t;
  localparam status_t ST_OK         = 4'd0;
  localparam status_t ST_EXP_AWR    = 4'd1;
  localparam status_t ST_EXP_SPACE  = 4'd2;
  localparam status_t ST_EXP_RWD    = 4'd3;
  localparam status_t ST_EXP_RD     = 4'd4;
  localparam status_t ST_EXP_DIGIT  = 4'd5;
  localparam status_t ST_BAD_DIGIT  = 4'd6;
  localparam status_t ST_OVERFLOW   = 4'd7;
  localparam status_t ST_TOO_MANY   = 4'd8;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NONE  = 2'd0;
  localparam mode_t MODE_QUERY = 2'd1;
  localparam mode_t MODE_GIVEN = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    status_t    status;
    mode_t      address_mode;
    logic [7:0] bus_address;
    logic [7:0] read_count;
    logic [4:0] write_count;
    logic [7:0] error_position;
    logic       last;
  } res_t;

  // Results produced by one accepted byte: none, one or two, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

### rtl/core/bclp_if.sv
// ----------------------------------------------------------------------------
// bclp_if: request channels of the bus command line parser
// Valid/ready channels for command text bytes and for result items.
// ----------------------------------------------------------------------------
interface bclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface bclp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [3:0] byte_index;
  logic [3:0] status;
  logic [1:0] address_mode;
  logic [7:0] bus_address;
  logic [7:0] read_count;
  logic [4:0] write_count;
  logic [7:0] error_position;
  logic       last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output address_mode, output bus_address,
                  output read_count, output write_count, output error_position,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input status, input address_mode, input bus_address,
                  input read_count, input write_count, input error_position,
                  input last, output ready);
endinterface

### rtl/core/bclp_core.sv
// ----------------------------------------------------------------------------
// bclp_core: command parser state and per-byte update
// Updates the parse state for one accepted byte and issues its results.
// ----------------------------------------------------------------------------
module bclp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      ch,
  output bclp_pkg::push_t push
);
  import bclp_pkg::*;

  typedef enum logic [3:0] {
    PS_BEGIN, PS_A, PS_A_F, PS_A_F_D, PS_R, PS_R_F, PS_R_F_D, PS_W, PS_W_F
  } pstate_t;

  typedef enum logic [1:0] {PH_NONE, PH_ZERO, PH_DIGITS} phase_t;
  typedef enum logic [1:0] {RX_DEC, RX_HEX, RX_OCT, RX_BIN} radix_t;
  typedef enum logic [1:0] {TG_ADDR, TG_READ, TG_WRITE} target_t;

  pstate_t    state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  radix_t     radix_r, radix_nxt;
  target_t    target_r, target_nxt;
  logic [7:0] accum_r, accum_nxt;
  mode_t      mode_r, mode_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] read_r, read_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  status_t    err_r, err_nxt;
  logic [7:0] pos_r, pos_nxt;

  // character classes
  logic       is_term, is_ws, is_dig, is_lhex, is_uhex, dig_ok;
  logic       is_a, is_r, is_w, is_x, is_b;
  logic [3:0] dval;
  radix_t     eff_radix;
  logic [4:0] rv;
  logic [11:0] scaled, v;

  assign is_term = (ch == 8'd0);
  assign is_ws   = (ch >= 8'd1) && (ch <= 8'd32);
  assign is_dig  = (ch >= "0") && (ch <= "9");
  assign is_lhex = (ch >= "a") && (ch <= "f");
  assign is_uhex = (ch >= "A") && (ch <= "F");
  assign dig_ok  = is_dig || is_lhex || is_uhex;
  assign is_a    = (ch == "a") || (ch == "A");
  assign is_r    = (ch == "r") || (ch == "R");
  assign is_w    = (ch == "w") || (ch == "W");
  assign is_x    = (ch == "x") || (ch == "X");
  assign is_b    = (ch == "b") || (ch == "B");
  assign dval    = is_dig ? ch[3:0] : ch[3:0] + 4'd9;

  // a leading zero without prefix letter makes the number octal
  assign eff_radix = (phase_r == PH_ZERO) ? RX_OCT : radix_r;

  always_comb begin
    case (eff_radix)
      RX_HEX:  begin rv = 5'd16; scaled = {accum_r, 4'b0000}; end
      RX_OCT:  begin rv = 5'd8;  scaled = {1'b0, accum_r, 3'b000}; end
      RX_BIN:  begin rv = 5'd2;  scaled = {3'b000, accum_r, 1'b0}; end
      default: begin
        rv     = 5'd10;
        scaled = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0};
      end
    endcase
  end

  assign v = scaled + {8'd0, dval};

  always_comb begin
    logic do_fin;
    logic start;
    logic wr_emit;
    res_t summ;

    do_fin     = 1'b0;
    start      = 1'b0;
    wr_emit    = 1'b0;
    summ       = '0;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    radix_nxt  = radix_r;
    target_nxt = target_r;
    accum_nxt  = accum_r;
    mode_nxt   = mode_r;
    addr_nxt   = addr_r;
    read_nxt   = read_r;
    wcnt_nxt   = wcnt_r;
    err_nxt    = err_r;
    pos_nxt    = pos_r;
    push       = '0;

    if (fire && !is_term && err_r == ST_OK) begin
      if (phase_r != PH_NONE) begin
        if (phase_r == PH_ZERO && (is_x || is_b)) begin
          phase_nxt = PH_DIGITS;
          radix_nxt = is_x ? RX_HEX : RX_BIN;
        end else begin
          phase_nxt = PH_DIGITS;
          radix_nxt = eff_radix;
          if (is_ws) begin
            do_fin = 1'b1;
          end else if (!dig_ok) begin
            err_nxt = ST_EXP_DIGIT;
          end else if ({1'b0, dval} >= rv) begin
            err_nxt = ST_BAD_DIGIT;
          end else if (v > 12'd255) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            accum_nxt = v[7:0];
          end
        end
      end else begin
        unique case (state_r)
          PS_BEGIN: begin
            if (is_ws) begin
            end else if (is_a) begin
              state_nxt = PS_A;
              mode_nxt  = MODE_QUERY;
            end else if (is_r) begin
              state_nxt = PS_R;
            end else if (is_w) begin
              state_nxt = PS_W;
            end else begin
              err_nxt = ST_EXP_AWR;
            end
          end
          PS_A: begin
            if (is_dig) begin
              state_nxt  = PS_A_F;
              start      = 1'b1;
              target_nxt = TG_ADDR;
            end else if (is_ws) begin
              state_nxt = PS_A_F;
            end else begin
              err_nxt = ST_EXP_SPACE;
            end
          end
          PS_A_F, PS_A_F_D: begin
            if (state_r == PS_A_F && is_dig) begin
              start      = 1'b1;
              target_nxt = TG_ADDR;
            end else if (is_r) begin
              state_nxt = PS_R;
            end else if (is_w) begin
              state_nxt = PS_W;
            end else if (!is_ws) begin
              err_nxt = ST_EXP_RWD;
            end
          end
          PS_R: begin
            if (is_dig) begin
              state_nxt  = PS_R_F;
              start      = 1'b1;
              target_nxt = TG_READ;
            end else if (is_ws) begin
              state_nxt = PS_R_F;
            end else begin
              err_nxt = ST_EXP_SPACE;
            end
          end
          PS_R_F: begin
            if (is_dig) begin
              start      = 1'b1;
              target_nxt = TG_READ;
            end else if (!is_ws) begin
              err_nxt = ST_EXP_DIGIT;
            end
          end
          PS_R_F_D: begin
            if (!is_ws) err_nxt = ST_EXP_SPACE;
          end
          PS_W, PS_W_F: begin
            if (state_r == PS_W && !is_dig && !is_ws) begin
              err_nxt = ST_EXP_SPACE;
            end else if (is_dig) begin
              state_nxt = PS_W_F;
              if (wcnt_r >= WCNT_W'(MAX_WRITE_BYTES)) begin
                err_nxt = ST_TOO_MANY;
              end else begin
                start      = 1'b1;
                target_nxt = TG_WRITE;
              end
            end else if (state_r == PS_W) begin
              state_nxt = PS_W_F;
            end else if (is_r) begin
              state_nxt = PS_R;
            end else if (!is_ws) begin
              err_nxt = ST_EXP_RD;
            end
          end
          default: state_nxt = PS_BEGIN;
        endcase
      end
    end

    if (start) begin
      if (ch == "0") begin
        phase_nxt = PH_ZERO;
        accum_nxt = 8'd0;
      end else begin
        phase_nxt = PH_DIGITS;
        radix_nxt = RX_DEC;
        accum_nxt = {4'd0, ch[3:0]};
      end
    end

    // a terminator ends an open number like whitespace does
    if (fire && is_term && err_r == ST_OK && phase_r != PH_NONE) do_fin = 1'b1;

    if (do_fin) begin
      phase_nxt = PH_NONE;
      case (target_r)
        TG_ADDR: begin
          addr_nxt  = accum_r;
          mode_nxt  = MODE_GIVEN;
          state_nxt = PS_A_F_D;
        end
        TG_READ: begin
          read_nxt  = accum_r;
          state_nxt = PS_R_F_D;
        end
        default: begin
          wr_emit   = 1'b1;
          wcnt_nxt  = wcnt_r + WCNT_W'(1);
          state_nxt = PS_W_F;
        end
      endcase
    end

    if (wr_emit) begin
      push.n             = 2'd1;
      push.r0.kind       = KIND_WRITE;
      push.r0.data_byte  = accum_r;
      push.r0.byte_index = wcnt_r[3:0];
    end

    if (fire && !is_term) begin
      if (err_nxt == ST_OK && pos_r != 8'hFF) pos_nxt = pos_r + 8'd1;
    end

    if (fire && is_term) begin
      summ.kind           = KIND_SUMMARY;
      summ.status         = err_r;
      summ.address_mode   = mode_nxt;
      summ.bus_address    = addr_nxt;
      summ.read_count     = read_nxt;
      summ.write_count    = wcnt_nxt[4:0];
      summ.error_position = (err_r != ST_OK) ? pos_r : 8'd0;
      summ.last           = 1'b1;
      if (wr_emit) begin
        push.n  = 2'd2;
        push.r1 = summ;
      end else begin
        push.n  = 2'd1;
        push.r0 = summ;
      end
      state_nxt  = PS_BEGIN;
      phase_nxt  = PH_NONE;
      radix_nxt  = RX_DEC;
      target_nxt = TG_ADDR;
      accum_nxt  = 8'd0;
      mode_nxt   = MODE_NONE;
      addr_nxt   = 8'd0;
      read_nxt   = 8'd0;
      wcnt_nxt   = '0;
      err_nxt    = ST_OK;
      pos_nxt    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= PS_BEGIN;
      phase_r  <= PH_NONE;
      radix_r  <= RX_DEC;
      target_r <= TG_ADDR;
      accum_r  <= 8'd0;
      mode_r   <= MODE_NONE;
      addr_r   <= 8'd0;
      read_r   <= 8'd0;
      wcnt_r   <= '0;
      err_r    <= ST_OK;
      pos_r    <= 8'd0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      radix_r  <= radix_nxt;
      target_r <= target_nxt;
      accum_r  <= accum_nxt;
      mode_r   <= mode_nxt;
      addr_r   <= addr_nxt;
      read_r   <= read_nxt;
      wcnt_r   <= wcnt_nxt;
      err_r    <= err_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

### rtl/core/bclp_outq.sv
// ----------------------------------------------------------------------------
// bclp_outq: result queue
// Takes up to two results per cycle, hands out one per cycle in order while popped.
// ----------------------------------------------------------------------------
module bclp_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  bclp_pkg::push_t  push,
  input  logic             pop,
  output logic             room,
  output logic             head_valid,
  output bclp_pkg::res_t   head
);
  import bclp_pkg::*;

  res_t                 mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OUTQ_AW:0]     cnt_r, cnt_nxt;

  // keep space for the largest burst one byte can cause
  assign room       = (cnt_r <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + OUTQ_AW'(push.n);
    rp_nxt  = rp_r + OUTQ_AW'(pop);
    cnt_nxt = cnt_r + (OUTQ_AW+1)'(push.n) - (OUTQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wp_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wp_r + OUTQ_AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/bus_command_line_parser.sv
// A result is written into the result queue when its byte is accepted and is offered
// at out_bus from the queue head. One byte is accepted per cycle while in_bus.ready is
// high; a terminator closing a write byte gives two results, the byte then the summary.
// in_bus.ready drops while the four-entry result queue has fewer than two free slots.
// Reset (rst_n low, synchronous): parser returns to the start of a command and
// the result queue empties.
// ----------------------------------------------------------------------------
// bus_command_line_parser: ASCII bus command parser
// Parses commands byte by byte, issuing write bytes and a command summary.
// ----------------------------------------------------------------------------
module bus_command_line_parser (
  input  logic       clk,
  input  logic       rst_n,
  bclp_in_if.sink    in_bus,
  bclp_out_if.source out_bus
);
  import bclp_pkg::*;

  logic  fire, pop, room, head_valid;
  push_t push;
  res_t  head;

  assign fire = in_bus.valid && in_bus.ready;
  assign pop  = out_bus.valid && out_bus.ready;

  bclp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ch    (in_bus.ch),
    .push  (push)
  );

  bclp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign in_bus.ready           = room;
  assign out_bus.valid          = head_valid;
  assign out_bus.kind           = head.kind;
  assign out_bus.data_byte      = head.data_byte;
  assign out_bus.byte_index     = head.byte_index;
  assign out_bus.status         = head.status;
  assign out_bus.address_mode   = head.address_mode;
  assign out_bus.bus_address    = head.bus_address;
  assign out_bus.read_count     = head.read_count;
  assign out_bus.write_count    = head.write_count;
  assign out_bus.error_position = head.error_position;
  assign out_bus.last           = head.last;

endmodule
